@@ rtl/dhb_pkg.sv @@
package dhb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [15:0] Half      = 16'd50;
  localparam logic [15:0] DutyFull  = 16'd255;
  localparam logic [28:0] Recip100  = 29'd5243;
  localparam int unsigned RecipShift = 19;
  localparam logic [7:0]  UnityPct  = 8'd100;
  localparam logic signed [7:0] RailLevel = 8'sd80;
  localparam logic signed [7:0] BumperMinCmd = 8'sd8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INVERT_ALL    = 3'd0,
    REG_INVERT_STEER  = 3'd1,
    REG_INVERT_DRIVE  = 3'd2,
    REG_STEER_REV     = 3'd3,
    REG_STEER_FWD     = 3'd4,
    REG_DRIVE_TRIM    = 3'd5,
    REG_BUMPER_STOP   = 3'd6,
    REG_BUMPER_ENABLE = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_COAST = 2'd0,
    MODE_PWM   = 2'd1,
    MODE_RAIL  = 2'd2
  } steer_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_DIV_A,
    ST_MUL_B,
    ST_DIV_B,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_A,
    OP_DIV_A,
    OP_MUL_B,
    OP_DIV_B,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic       invert_all;
    logic       invert_steer;
    logic       invert_drive;
    logic [6:0] steer_reverse_trim_pct;
    logic [7:0] steer_forward_scale_pct;
    logic [6:0] drive_trim_pct;
    logic [9:0] bumper_stop_tenths;
    logic       bumper_enabled;
    logic       set_force;
    logic       clr_blocked;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic leg;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic signed [15:0] steer_speed;
    logic signed [15:0] drive_speed;
    logic [12:0]        range_tenths;
    logic               sensor_present;
  } in_item_t;

  typedef struct packed {
    logic [1:0] steer_mode;
    logic [7:0] steer_ia_duty;
    logic       steer_ib_level;
    logic [7:0] drive_ia_duty;
    logic       drive_ib_level;
    logic       steer_changed;
    logic       drive_changed;
    logic       bumper_blocked;
  } out_item_t;

  function automatic logic signed [7:0] sat100(logic signed [15:0] v);
    logic signed [7:0] r;
    if (v > 16'sd100) begin
      r = 8'sd100;
    end else if (v < -16'sd100) begin
      r = -8'sd100;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/dhb_in_if.sv @@
interface dhb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] steer_speed;
  logic signed [15:0] drive_speed;
  logic [12:0]        range_tenths;
  logic               sensor_present;

  modport source (
    output valid, steer_speed, drive_speed, range_tenths, sensor_present,
    input  ready
  );
  modport sink (
    input  valid, steer_speed, drive_speed, range_tenths, sensor_present,
    output ready
  );
endinterface

@@ rtl/dhb_out_if.sv @@
interface dhb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] steer_mode;
  logic [7:0] steer_ia_duty;
  logic       steer_ib_level;
  logic [7:0] drive_ia_duty;
  logic       drive_ib_level;
  logic       steer_changed;
  logic       drive_changed;
  logic       bumper_blocked;

  modport source (
    output valid, steer_mode, steer_ia_duty, steer_ib_level, drive_ia_duty,
           drive_ib_level, steer_changed, drive_changed, bumper_blocked,
    input  ready
  );
  modport sink (
    input  valid, steer_mode, steer_ia_duty, steer_ib_level, drive_ia_duty,
           drive_ib_level, steer_changed, drive_changed, bumper_blocked,
    output ready
  );
endinterface

@@ rtl/dual_hbridge_drive_with_bumper_top.sv @@
// Dual H-bridge drive with a forward bumper.
// The input channel carries a steer command, a drive command and an optional
// range reading; the output channel carries the leg drive of both bridges,
// the per-leg change flags and the bumper blocked flag. Both channels move
// one item per transfer when valid and ready are high at a rising edge.
// An item is taken in the idle state, then a shared multiply unit works the
// duty of the steer leg and then of the drive leg, each through a multiply,
// divide, multiply and divide state. The out state then loads the result,
// and a new item can be accepted from the cycle after that load. The result
// sits in an output register; the next item is taken and worked while it
// waits, and only the final load waits for the receiver.
// Configuration writes take effect at the edge where the write enable is
// high and belong in idle periods. Reset restores the default trims, the
// stop distance and the enabled bumper, clears the last commands, the
// blocked flag and the re-apply flag, and empties the output register.
module dual_hbridge_drive_with_bumper_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dhb_in_if.sink                       in_i,
  dhb_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [dhb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhb_pkg::CfgDataW-1:0] cfg_data_i
);

  dhb_pkg::cfg_t       cfg;
  dhb_pkg::dp_cmd_t    cmd;
  dhb_pkg::dp_status_t status;
  dhb_pkg::in_item_t   in_item;
  dhb_pkg::out_item_t  out_item;
  logic                in_ready;
  logic                out_valid;

  assign in_item.steer_speed    = in_i.steer_speed;
  assign in_item.drive_speed    = in_i.drive_speed;
  assign in_item.range_tenths   = in_i.range_tenths;
  assign in_item.sensor_present = in_i.sensor_present;
  assign in_i.ready             = in_ready;

  assign out_o.valid          = out_valid;
  assign out_o.steer_mode     = out_item.steer_mode;
  assign out_o.steer_ia_duty  = out_item.steer_ia_duty;
  assign out_o.steer_ib_level = out_item.steer_ib_level;
  assign out_o.drive_ia_duty  = out_item.drive_ia_duty;
  assign out_o.drive_ib_level = out_item.drive_ib_level;
  assign out_o.steer_changed  = out_item.steer_changed;
  assign out_o.drive_changed  = out_item.drive_changed;
  assign out_o.bumper_blocked = out_item.bumper_blocked;

  dhb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dhb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_item_i   (in_item),
    .out_item_o  (out_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

endmodule

@@ rtl/dhb_cfg_regs.sv @@
module dhb_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dhb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dhb_pkg::CfgDataW-1:0] cfg_data_i,
  output dhb_pkg::cfg_t                cfg_o
);

  logic       inv_all_q, inv_steer_q, inv_drive_q, bump_en_q;
  logic [6:0] rev_q, trim_q;
  logic [7:0] fwd_q;
  logic [9:0] stop_q;
  logic [6:0] v7;
  logic [7:0] v8;
  logic [9:0] v10;
  logic [6:0] v7_sat;
  logic [7:0] v8_sat;
  logic [9:0] v10_sat;
  dhb_pkg::cfg_idx_e idx;

  assign idx = dhb_pkg::cfg_idx_e'(cfg_idx_i);
  assign v7  = cfg_data_i[6:0];
  assign v8  = cfg_data_i[7:0];
  assign v10 = cfg_data_i;

  always_comb begin
    if (v7 < 7'd50) begin
      v7_sat = 7'd50;
    end else if (v7 > 7'd120) begin
      v7_sat = 7'd120;
    end else begin
      v7_sat = v7;
    end
    v8_sat = (v8 > 8'd200) ? 8'd200 : v8;
    if (v10 < 10'd50) begin
      v10_sat = 10'd50;
    end else if (v10 > 10'd800) begin
      v10_sat = 10'd800;
    end else begin
      v10_sat = v10;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_all_q   <= 1'b0;
      inv_steer_q <= 1'b0;
      inv_drive_q <= 1'b0;
      rev_q       <= 7'd100;
      fwd_q       <= 8'd100;
      trim_q      <= 7'd100;
      stop_q      <= 10'd100;
      bump_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (idx)
        dhb_pkg::REG_INVERT_ALL:    inv_all_q   <= cfg_data_i[0];
        dhb_pkg::REG_INVERT_STEER:  inv_steer_q <= cfg_data_i[0];
        dhb_pkg::REG_INVERT_DRIVE:  inv_drive_q <= cfg_data_i[0];
        dhb_pkg::REG_STEER_REV:     rev_q       <= v7_sat;
        dhb_pkg::REG_STEER_FWD:     fwd_q       <= v8_sat;
        dhb_pkg::REG_DRIVE_TRIM:    trim_q      <= v7_sat;
        dhb_pkg::REG_BUMPER_STOP:   stop_q      <= v10_sat;
        dhb_pkg::REG_BUMPER_ENABLE: bump_en_q   <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    cfg_o.invert_all              = inv_all_q;
    cfg_o.invert_steer            = inv_steer_q;
    cfg_o.invert_drive            = inv_drive_q;
    cfg_o.steer_reverse_trim_pct  = rev_q;
    cfg_o.steer_forward_scale_pct = fwd_q;
    cfg_o.drive_trim_pct          = trim_q;
    cfg_o.bumper_stop_tenths      = stop_q;
    cfg_o.bumper_enabled          = bump_en_q;
    cfg_o.set_force   = cfg_we_i && (idx == dhb_pkg::REG_STEER_REV ||
                                     idx == dhb_pkg::REG_STEER_FWD ||
                                     idx == dhb_pkg::REG_DRIVE_TRIM);
    cfg_o.clr_blocked = cfg_we_i && (idx == dhb_pkg::REG_BUMPER_ENABLE) &&
                        !cfg_data_i[0];
  end

endmodule

@@ rtl/dhb_ctrl.sv @@
module dhb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dhb_pkg::dp_status_t status_i,
  output dhb_pkg::dp_cmd_t    cmd_o
);

  dhb_pkg::state_e state_q, state_d;
  logic            leg_q, leg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dhb_pkg::ST_IDLE;
      leg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
    end
  end

  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    unique case (state_q)
      dhb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = dhb_pkg::ST_MUL_A;
          leg_d   = 1'b0;
        end
      end
      dhb_pkg::ST_MUL_A: state_d = dhb_pkg::ST_DIV_A;
      dhb_pkg::ST_DIV_A: state_d = dhb_pkg::ST_MUL_B;
      dhb_pkg::ST_MUL_B: state_d = dhb_pkg::ST_DIV_B;
      dhb_pkg::ST_DIV_B: begin
        if (leg_q) begin
          state_d = dhb_pkg::ST_OUT;
        end else begin
          state_d = dhb_pkg::ST_MUL_A;
          leg_d   = 1'b1;
        end
      end
      dhb_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          state_d = dhb_pkg::ST_IDLE;
        end
      end
      default: state_d = dhb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = dhb_pkg::OP_NONE;
    cmd_o.leg  = leg_q;
    unique case (state_q)
      dhb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = dhb_pkg::OP_LOAD;
        end
      end
      dhb_pkg::ST_MUL_A: cmd_o.op = dhb_pkg::OP_MUL_A;
      dhb_pkg::ST_DIV_A: cmd_o.op = dhb_pkg::OP_DIV_A;
      dhb_pkg::ST_MUL_B: cmd_o.op = dhb_pkg::OP_MUL_B;
      dhb_pkg::ST_DIV_B: cmd_o.op = dhb_pkg::OP_DIV_B;
      dhb_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = dhb_pkg::OP_OUT;
        end
      end
      default: cmd_o.op = dhb_pkg::OP_NONE;
    endcase
  end

endmodule

@@ rtl/dhb_datapath.sv @@
module dhb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhb_pkg::cfg_t       cfg_i,
  input  dhb_pkg::dp_cmd_t    cmd_i,
  output dhb_pkg::dp_status_t status_o,
  input  dhb_pkg::in_item_t   in_item_i,
  output dhb_pkg::out_item_t  out_item_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);

  logic signed [7:0] steer8, drive8, drive_b, s_cmd, d_cmd;
  logic              both_zero, hit;

  logic signed [7:0] s_cmd_q, d_cmd_q, last_s_q, last_d_q;
  logic              force_q, blocked_q, s_chg_q, d_chg_q;

  logic signed [7:0] sel_cmd;
  logic [7:0]        sel_abs, sel_scale;
  logic [6:0]        mag_q;
  logic              unity_q;
  logic [15:0]       prod_q, prod_d;
  logic [7:0]        mag2_q;
  logic [28:0]       quot_full;
  logic [7:0]        quot;
  logic [7:0]        duty;
  logic [7:0]        s_duty_q, d_duty_q;

  dhb_pkg::out_item_t out_q, out_d;
  logic               out_valid_q;

  assign steer8    = dhb_pkg::sat100(in_item_i.steer_speed);
  assign drive8    = dhb_pkg::sat100(in_item_i.drive_speed);
  assign both_zero = (steer8 == 8'sd0) && (drive8 == 8'sd0);
  assign hit       = cfg_i.bumper_enabled && in_item_i.sensor_present &&
                     (drive8 > dhb_pkg::BumperMinCmd) &&
                     (in_item_i.range_tenths != 13'd0) &&
                     (in_item_i.range_tenths < {3'd0, cfg_i.bumper_stop_tenths});
  assign drive_b   = hit ? 8'sd0 : drive8;
  assign s_cmd     = (cfg_i.invert_all ^ cfg_i.invert_steer) ? -steer8 : steer8;
  assign d_cmd     = (cfg_i.invert_all ^ cfg_i.invert_drive) ? -drive_b : drive_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_s_q  <= 8'sd0;
      last_d_q  <= 8'sd0;
      force_q   <= 1'b0;
      blocked_q <= 1'b0;
    end else if (cmd_i.op == dhb_pkg::OP_LOAD) begin
      last_s_q  <= s_cmd;
      last_d_q  <= d_cmd;
      force_q   <= 1'b0;
      blocked_q <= hit;
    end else begin
      if (cfg_i.set_force) begin
        force_q <= 1'b1;
      end
      if (cfg_i.clr_blocked) begin
        blocked_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dhb_pkg::OP_LOAD) begin
      s_cmd_q <= s_cmd;
      d_cmd_q <= d_cmd;
      s_chg_q <= both_zero || force_q || (s_cmd != last_s_q);
      d_chg_q <= both_zero || force_q || (d_cmd != last_d_q);
    end
  end

  assign sel_cmd = cmd_i.leg ? d_cmd_q : s_cmd_q;
  assign sel_abs = sel_cmd[7] ? 8'(-sel_cmd) : 8'(sel_cmd);

  always_comb begin
    if (cmd_i.leg) begin
      sel_scale = {1'b0, cfg_i.drive_trim_pct};
    end else if (sel_cmd[7]) begin
      sel_scale = {1'b0, cfg_i.steer_reverse_trim_pct};
    end else begin
      sel_scale = cfg_i.steer_forward_scale_pct;
    end
  end

  // Division by 100 is a multiply by a reciprocal, exact for dividends below
  // 43690, which covers every product whose quotient is used.
  assign quot_full = {13'd0, prod_q} * dhb_pkg::Recip100;
  assign quot      = quot_full[dhb_pkg::RecipShift+7:dhb_pkg::RecipShift];

  always_comb begin
    prod_d = prod_q;
    if (cmd_i.op == dhb_pkg::OP_MUL_A) begin
      prod_d = 16'({9'd0, sel_abs[6:0]} * {8'd0, sel_scale}) + dhb_pkg::Half;
    end else if (cmd_i.op == dhb_pkg::OP_MUL_B) begin
      prod_d = 16'({8'd0, mag2_q} * dhb_pkg::DutyFull) + dhb_pkg::Half;
    end
  end

  always_comb begin
    if (mag2_q == 8'd0) begin
      duty = 8'd0;
    end else if (mag2_q >= 8'd100) begin
      duty = 8'd255;
    end else begin
      duty = quot;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.op == dhb_pkg::OP_MUL_A) begin
      mag_q   <= sel_abs[6:0];
      unity_q <= (sel_scale == dhb_pkg::UnityPct);
    end
    if (cmd_i.op == dhb_pkg::OP_DIV_A) begin
      mag2_q <= unity_q ? {1'b0, mag_q} : quot;
    end
    if (cmd_i.op == dhb_pkg::OP_DIV_B) begin
      if (cmd_i.leg) begin
        d_duty_q <= duty;
      end else begin
        s_duty_q <= duty;
      end
    end
  end

  always_comb begin
    out_d = '0;
    if (s_cmd_q == 8'sd0) begin
      out_d.steer_mode = dhb_pkg::MODE_COAST;
    end else if (s_cmd_q >= dhb_pkg::RailLevel || s_cmd_q <= -dhb_pkg::RailLevel) begin
      out_d.steer_mode     = dhb_pkg::MODE_RAIL;
      out_d.steer_ia_duty  = s_cmd_q[7] ? 8'd0 : 8'd255;
      out_d.steer_ib_level = s_cmd_q[7];
    end else begin
      out_d.steer_mode     = dhb_pkg::MODE_PWM;
      out_d.steer_ia_duty  = s_cmd_q[7] ? (8'd255 - s_duty_q) : s_duty_q;
      out_d.steer_ib_level = s_cmd_q[7];
    end
    if (d_cmd_q != 8'sd0) begin
      out_d.drive_ia_duty  = d_cmd_q[7] ? (8'd255 - d_duty_q) : d_duty_q;
      out_d.drive_ib_level = d_cmd_q[7];
    end
    out_d.steer_changed  = s_chg_q;
    out_d.drive_changed  = d_chg_q;
    out_d.bumper_blocked = blocked_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == dhb_pkg::OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dhb_pkg::OP_OUT) begin
      out_q <= out_d;
    end
  end

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import dhb_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandPhases = 12;
  localparam int unsigned ItemsPerPhase = 54;
  localparam int unsigned SettleCycles = 12;

  typedef struct packed {
    cfg_idx_e   idx;
    logic [9:0] data;
  } reg_write_t;

  typedef struct packed {
    in_item_t  stim;
    logic      known;
    out_item_t want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dhb_in_if in_if ();
  dhb_out_if out_if ();

  dual_hbridge_drive_with_bumper_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the registers and leg state.
  bit inv_all_m = 1'b0;
  bit inv_steer_m = 1'b0;
  bit inv_drive_m = 1'b0;
  int steer_rev_pct = 100;
  int steer_fwd_pct = 100;
  int drive_trim_m = 100;
  int stop_tenths = 100;
  bit bumper_on = 1'b1;
  int last_steer = 0;
  int last_drive = 0;
  bit reapply_pending = 1'b0;
  bit blocked_now = 1'b0;

  out_item_t leg_drive_q[$];
  reg_write_t pending_writes[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit no_gaps = 1'b0;
  logic signed [15:0] prev_steer = '0;
  logic signed [15:0] prev_drive = '0;

  int speed_edges [19] = '{0, 1, -1, 8, 9, -8, -9, 79, 80, 81, -79, -80, -81,
                           100, 101, -100, -101, 32767, -32768};

  drill_row_t drills [20] = '{
    '{'{16'sd0, 16'sd0, 13'd0, 1'b0}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{16'sd32767, 16'sd32767, 13'd8191, 1'b1}, 1'b1,
      '{MODE_RAIL, 8'd255, 1'b0, 8'd255, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{16'sd32767, 16'sd32767, 13'd8191, 1'b1}, 1'b1,
      '{MODE_RAIL, 8'd255, 1'b0, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{'{-16'sd32768, -16'sd32768, 13'd0, 1'b0}, 1'b1,
      '{MODE_RAIL, 8'd0, 1'b1, 8'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{'{16'sd80, 16'sd50, 13'd0, 1'b0}, 1'b0, '0},
    '{'{16'sd79, -16'sd1, 13'd0, 1'b1}, 1'b0, '0},
    '{'{-16'sd79, 16'sd1, 13'd100, 1'b1}, 1'b0, '0},
    '{'{-16'sd80, 16'sd9, 13'd99, 1'b1}, 1'b1,
      '{MODE_RAIL, 8'd0, 1'b1, 8'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{'{-16'sd80, 16'sd8, 13'd50, 1'b1}, 1'b0, '0},
    '{'{16'sd0, 16'sd100, 13'd0, 1'b1}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd255, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{16'sd0, 16'sd100, 13'd1, 1'b1}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{16'sd0, 16'sd100, 13'd1, 1'b0}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd255, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{16'sd0, 16'sd0, 13'd1, 1'b1}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0}},
    '{'{16'sd5, 16'sd101, 13'd99, 1'b1}, 1'b0, '0},
    '{'{-16'sd1, -16'sd100, 13'd8191, 1'b1}, 1'b0, '0},
    '{'{16'sd1, 16'sd0, 13'd4096, 1'b1}, 1'b0, '0},
    '{'{-16'sd32767, 16'sd32767, 13'd99, 1'b0}, 1'b0, '0},
    '{'{16'sd100, -16'sd32768, 13'd1, 1'b1}, 1'b0, '0},
    '{'{-16'sd100, 16'sd9, 13'd99, 1'b1}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 13'd0, 1'b0}, 1'b1,
      '{MODE_COAST, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 1'b0}}
  };

  function automatic int clamp(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int scaled_duty(int cmd, int scale);
    int mag;
    mag = (cmd < 0) ? -cmd : cmd;
    if (scale != 100) mag = (mag * scale + 50) / 100;
    if (mag <= 0) return 0;
    if (mag >= 100) return 255;
    return (mag * 255 + 50) / 100;
  endfunction

  function automatic void apply_reg(cfg_idx_e idx, logic [9:0] data);
    case (idx)
      REG_INVERT_ALL: inv_all_m = data[0];
      REG_INVERT_STEER: inv_steer_m = data[0];
      REG_INVERT_DRIVE: inv_drive_m = data[0];
      REG_STEER_REV: begin
        steer_rev_pct = clamp(int'(data[6:0]), 50, 120);
        reapply_pending = 1'b1;
      end
      REG_STEER_FWD: begin
        steer_fwd_pct = clamp(int'(data[7:0]), 0, 200);
        reapply_pending = 1'b1;
      end
      REG_DRIVE_TRIM: begin
        drive_trim_m = clamp(int'(data[6:0]), 50, 120);
        reapply_pending = 1'b1;
      end
      REG_BUMPER_STOP: stop_tenths = clamp(int'(data), 50, 800);
      REG_BUMPER_ENABLE: begin
        bumper_on = data[0];
        if (!data[0]) blocked_now = 1'b0;
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_legs(in_item_t it);
    int steer;
    int drive;
    int s_cmd;
    int d_cmd;
    int duty;
    out_item_t r;
    r = '0;
    steer = clamp(int'($signed(it.steer_speed)), -100, 100);
    drive = clamp(int'($signed(it.drive_speed)), -100, 100);
    if (steer == 0 && drive == 0) begin
      blocked_now = 1'b0;
      last_steer = 0;
      last_drive = 0;
      r.steer_changed = 1'b1;
      r.drive_changed = 1'b1;
    end else begin
      if (bumper_on && it.sensor_present && drive > 8 && it.range_tenths != '0 &&
          int'(it.range_tenths) < stop_tenths) begin
        blocked_now = 1'b1;
        drive = 0;
      end else begin
        blocked_now = 1'b0;
      end
      s_cmd = steer;
      if (inv_all_m) s_cmd = -s_cmd;
      if (inv_steer_m) s_cmd = -s_cmd;
      d_cmd = drive;
      if (inv_all_m) d_cmd = -d_cmd;
      if (inv_drive_m) d_cmd = -d_cmd;
      r.steer_changed = reapply_pending || s_cmd != last_steer;
      r.drive_changed = reapply_pending || d_cmd != last_drive;
      last_steer = s_cmd;
      last_drive = d_cmd;
      if (s_cmd != 0) begin
        r.steer_ib_level = (s_cmd < 0);
        if (s_cmd >= 80 || s_cmd <= -80) begin
          r.steer_mode = MODE_RAIL;
          r.steer_ia_duty = (s_cmd > 0) ? 8'd255 : 8'd0;
        end else begin
          duty = scaled_duty(s_cmd, (s_cmd < 0) ? steer_rev_pct : steer_fwd_pct);
          r.steer_mode = MODE_PWM;
          r.steer_ia_duty = 8'((s_cmd > 0) ? duty : 255 - duty);
        end
      end
      if (d_cmd != 0) begin
        duty = scaled_duty(d_cmd, drive_trim_m);
        r.drive_ia_duty = 8'((d_cmd > 0) ? duty : 255 - duty);
        r.drive_ib_level = (d_cmd < 0);
      end
    end
    reapply_pending = 1'b0;
    r.bumper_blocked = blocked_now;
    return r;
  endfunction

  function automatic int gap_draw();
    return no_gaps ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic logic signed [15:0] pick_speed(logic signed [15:0] prev);
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 35) v = int'($urandom_range(0, 200)) - 100;
    else if (sel < 55) v = speed_edges[$urandom_range(0, 18)];
    else if (sel < 75) v = int'(prev);
    else if (sel < 85) v = 0;
    else v = int'($urandom);
    return v[15:0];
  endfunction

  function automatic in_item_t rand_command();
    in_item_t it;
    int sel;
    it.steer_speed = pick_speed(prev_steer);
    it.drive_speed = pick_speed(prev_drive);
    if ($urandom_range(0, 19) == 0) begin
      it.steer_speed = '0;
      it.drive_speed = '0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 50) it.range_tenths = 13'($urandom_range(0, 900));
    else if (sel < 60) it.range_tenths = '0;
    else if (sel < 70) it.range_tenths = 13'($urandom_range(stop_tenths - 1, stop_tenths + 1));
    else it.range_tenths = 13'($urandom_range(0, 8191));
    it.sensor_present = ($urandom_range(0, 3) != 0);
    prev_steer = it.steer_speed;
    prev_drive = it.drive_speed;
    return it;
  endfunction

  task automatic load_regs();
    foreach (pending_writes[k]) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= pending_writes[k].idx;
      cfg_data_i <= pending_writes[k].data;
      apply_reg(pending_writes[k].idx, pending_writes[k].data);
    end
    if (pending_writes.size() != 0) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
    end
    pending_writes.delete();
  endtask

  task automatic push_command(in_item_t it, logic known, out_item_t want);
    int gap;
    out_item_t pred;
    gap = gap_draw();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.steer_speed <= it.steer_speed;
    in_if.drive_speed <= it.drive_speed;
    in_if.range_tenths <= it.range_tenths;
    in_if.sensor_present <= it.sensor_present;
    do @(posedge clk_i); while (!in_if.ready);
    pred = predict_legs(it);
    leg_drive_q.push_back(known ? want : pred);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (leg_drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    out_item_t got;
    out_item_t want;
    got = '{out_if.steer_mode, out_if.steer_ia_duty, out_if.steer_ib_level,
            out_if.drive_ia_duty, out_if.drive_ib_level, out_if.steer_changed,
            out_if.drive_changed, out_if.bumper_blocked};
    if (leg_drive_q.size() == 0) begin
      $display("%0t: result with nothing expected, expected none, got %h", $time, got);
      mismatches++;
    end else begin
      want = leg_drive_q.pop_front();
      compare_field("steer_mode", want.steer_mode, got.steer_mode);
      compare_field("steer_ia_duty", want.steer_ia_duty, got.steer_ia_duty);
      compare_field("steer_ib_level", want.steer_ib_level, got.steer_ib_level);
      compare_field("drive_ia_duty", want.drive_ia_duty, got.drive_ia_duty);
      compare_field("drive_ib_level", want.drive_ib_level, got.drive_ib_level);
      compare_field("steer_changed", want.steer_changed, got.steer_changed);
      compare_field("drive_changed", want.drive_changed, got.drive_changed);
      compare_field("bumper_blocked", want.bumper_blocked, got.bumper_blocked);
    end
  endtask

  // Receiver with random stalls before each transfer.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = gap_draw();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      check_result();
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.steer_speed <= '0;
    in_if.drive_speed <= '0;
    in_if.range_tenths <= '0;
    in_if.sensor_present <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (drills[i]) push_command(drills[i].stim, drills[i].known, drills[i].want);
    drain();

    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        pending_writes.push_back('{REG_INVERT_ALL, 10'd1});
        pending_writes.push_back('{REG_STEER_REV, 10'd0});
        pending_writes.push_back('{REG_STEER_FWD, 10'd0});
        pending_writes.push_back('{REG_DRIVE_TRIM, 10'h07F});
        pending_writes.push_back('{REG_BUMPER_STOP, 10'h3FF});
      end else if (p == 1) begin
        pending_writes.push_back('{REG_INVERT_ALL, 10'h3FE});
        pending_writes.push_back('{REG_INVERT_STEER, 10'd1});
        pending_writes.push_back('{REG_INVERT_DRIVE, 10'h3FF});
        pending_writes.push_back('{REG_STEER_REV, 10'd120});
        pending_writes.push_back('{REG_STEER_FWD, 10'h0FF});
        pending_writes.push_back('{REG_DRIVE_TRIM, 10'd50});
        pending_writes.push_back('{REG_BUMPER_STOP, 10'd0});
        pending_writes.push_back('{REG_BUMPER_ENABLE, 10'd0});
      end else if (p == 2) begin
        pending_writes.push_back('{REG_INVERT_STEER, 10'd0});
        pending_writes.push_back('{REG_INVERT_DRIVE, 10'd0});
        pending_writes.push_back('{REG_STEER_FWD, 10'd200});
        pending_writes.push_back('{REG_BUMPER_STOP, 10'd800});
        pending_writes.push_back('{REG_BUMPER_ENABLE, 10'd1});
      end else begin
        for (int r = 0; r < 8; r++) begin
          if ($urandom_range(0, 1) == 1) begin
            pending_writes.push_back('{cfg_idx_e'(r), 10'($urandom_range(0, 1023))});
          end
        end
      end
      load_regs();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ItemsPerPhase; n++) push_command(rand_command(), 1'b0, '0);
      drain();
    end

    if (mismatches == 0 && leg_drive_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
